@@ src/sstw_pkg.sv @@
// Package of the two-wire seven-segment writer: request codes, register
// indexes, shared structs, the segment table and the frame phase decoder.
// Depends on nothing.
package sstw_pkg;

   localparam int SSTW_COUNTER_WIDTH = 16;
   localparam int PHASE_TICKS_W      = 16;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int DIGITS             = 4;
   localparam int PHASE_W            = 6;
   localparam int FRAMES_W           = 3;

   localparam logic [PHASE_W-1:0] LAST_PHASE = 6'd55;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_SHOW = 2'd1;
   localparam logic [1:0] REQ_RAW  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_TICKS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT0_ADDR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT1_ADDR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT2_ADDR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT3_ADDR = 3'd4;

   localparam logic [FRAMES_W-1:0] SHOW_FRAMES = 3'd4;
   localparam logic [FRAMES_W-1:0] RAW_FRAMES  = 3'd1;

   localparam logic [7:0] DOT_SEGMENT = 8'h80;

   typedef struct packed {
      logic [PHASE_TICKS_W-1:0] phase_ticks;
      logic [DIGITS-1:0][7:0]   digit_address;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] digit_a;
      logic [3:0] digit_b;
      logic [3:0] digit_c;
      logic [3:0] digit_d;
      logic       dot_on;
      logic [7:0] raw_command;
      logic [7:0] raw_payload;
   } request_type;

   typedef struct packed {
      logic clock_pin;
      logic data_pin;
      logic busy_res;
      logic rejected;
   } result_type;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] payload;
   } pair_type;

   typedef struct packed {
      logic clock_level;
      logic data_level;
   } levels_type;

   // Symbols 0-9, then H, dash and E; anything else is blank.
   function automatic logic [7:0] segment_of(input logic [3:0] code);
      logic [7:0] seg;
      case (code)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         4'd10:   seg = 8'h76;
         4'd11:   seg = 8'h40;
         4'd12:   seg = 8'h79;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   // Pin levels of one phase of a 56-phase frame carrying one byte pair.
   function automatic levels_type phase_levels(input logic [PHASE_W-1:0] p,
                                               input pair_type pair);
      levels_type lv;
      logic [4:0] q;
      logic [2:0] bit_n;
      logic [4:0] sub;
      logic [7:0] b;
      lv    = '{clock_level: 1'b1, data_level: 1'b1};
      q     = '0;
      bit_n = '0;
      b     = pair.command;
      if (p < 6'd3) begin
         lv.clock_level = (p != 6'd2);
         lv.data_level  = (p == 6'd0);
      end else if (p < 6'd27 || (p >= 6'd28 && p < 6'd52)) begin
         if (p < 6'd27) begin
            q = 5'(p - 6'd3);
            b = pair.command;
         end else begin
            q = 5'(p - 6'd28);
            b = pair.payload;
         end
         // Bit number is q divided by three, found by independent compares.
         for (int i = 1; i < 8; i++) begin
            if (q >= 5'(3 * i)) begin
               bit_n = 3'(i);
            end
         end
         sub = q - 5'({bit_n, 1'b0} + {2'b00, bit_n});
         lv.clock_level = (sub == 5'd1);
         lv.data_level  = b[3'd7 - bit_n];
      end else if (p == 6'd27 || p == 6'd52) begin
         lv.clock_level = 1'b1;
         lv.data_level  = 1'b0;
      end else begin
         lv.clock_level = (p != 6'd53);
         lv.data_level  = (p >= 6'd55);
      end
      return lv;
   endfunction

endpackage

@@ src/sstw_engine.sv @@
// Frame engine of the two-wire seven-segment writer: bus state, byte pairs
// and phase timing, advanced once per step. Depends on sstw_pkg.
module sstw_engine import sstw_pkg::*; #(
   parameter int COUNTER_WIDTH = SSTW_COUNTER_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  request_type request,
   input  cfg_type     cfg,
   output result_type  result
);

   localparam int CMP_W = (COUNTER_WIDTH + 1 > PHASE_TICKS_W + 1) ?
                          COUNTER_WIDTH + 1 : PHASE_TICKS_W + 1;

   logic                     clock_level_ff, clock_level_in;
   logic                     data_level_ff, data_level_in;
   logic [COUNTER_WIDTH-1:0] hold_ff, hold_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [FRAMES_W-1:0]      frames_left_ff, frames_left_in;
   pair_type                 pairs_ff [DIGITS];
   pair_type                 pairs_in [DIGITS];

   logic                     is_request;
   logic                     load;
   logic                     active_now;
   logic [COUNTER_WIDTH-1:0] hold_now;
   logic [PHASE_W-1:0]       phase_now;
   logic [FRAMES_W-1:0]      frames_now;
   pair_type                 pairs_now [DIGITS];
   logic [CMP_W-1:0]         hold_inc;
   logic [CMP_W-1:0]         limit;
   logic                     advance;
   logic [7:0]               third_seg;
   levels_type               lv;

   always_comb begin
      is_request = (request.req_type == REQ_SHOW) || (request.req_type == REQ_RAW);
      load       = is_request && (frames_left_ff == '0);

      third_seg = segment_of(request.digit_c);
      if (request.dot_on) begin
         third_seg = third_seg | DOT_SEGMENT;
      end

      pairs_now  = pairs_ff;
      frames_now = frames_left_ff;
      hold_now   = hold_ff;
      phase_now  = phase_ff;
      if (load) begin
         hold_now  = '0;
         phase_now = '0;
         if (request.req_type == REQ_SHOW) begin
            pairs_now[0] = '{cfg.digit_address[0], segment_of(request.digit_a)};
            pairs_now[1] = '{cfg.digit_address[1], segment_of(request.digit_b)};
            pairs_now[2] = '{cfg.digit_address[2], third_seg};
            pairs_now[3] = '{cfg.digit_address[3], segment_of(request.digit_d)};
            frames_now   = SHOW_FRAMES;
         end else begin
            pairs_now[0] = '{request.raw_command, request.raw_payload};
            frames_now   = RAW_FRAMES;
         end
      end
      active_now = (frames_now != '0);

      // A zero hold is taken as one; a hold past the counter range ends at wrap.
      limit    = (cfg.phase_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.phase_ticks);
      hold_inc = CMP_W'(hold_now) + CMP_W'(1);
      advance  = (hold_inc >= limit) || (hold_now == '1);

      lv = phase_levels(phase_now, pairs_now[0]);

      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      hold_in        = hold_now;
      phase_in       = phase_now;
      frames_left_in = frames_now;
      pairs_in       = pairs_now;
      if (active_now) begin
         clock_level_in = lv.clock_level;
         data_level_in  = lv.data_level;
         if (advance) begin
            hold_in = '0;
            if (phase_now == LAST_PHASE) begin
               phase_in       = '0;
               frames_left_in = frames_now - FRAMES_W'(1);
               // The next frame's pair moves to the front of the line.
               for (int i = 0; i < DIGITS - 1; i++) begin
                  pairs_in[i] = pairs_now[i + 1];
               end
            end else begin
               phase_in = phase_now + PHASE_W'(1);
            end
         end else begin
            hold_in = COUNTER_WIDTH'(hold_inc);
         end
      end

      result.clock_pin = clock_level_in;
      result.data_pin  = data_level_in;
      result.busy_res  = active_now;
      result.rejected  = is_request && !load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_level_ff <= 1'b1;
         data_level_ff  <= 1'b1;
         hold_ff        <= '0;
         phase_ff       <= '0;
         frames_left_ff <= '0;
      end else if (step) begin
         clock_level_ff <= clock_level_in;
         data_level_ff  <= data_level_in;
         hold_ff        <= hold_in;
         phase_ff       <= phase_in;
         frames_left_ff <= frames_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pairs_ff <= pairs_in;
      end
   end

endmodule

@@ src/seven_segment_two_wire_writer.sv @@
// Top level of the two-wire seven-segment writer: configuration registers,
// request handshake and the result register. Depends on sstw_pkg and
// sstw_engine.
//
// Every request word is one time tick. A word with req_type show maps four
// symbol codes to segment patterns and sends four frames, one per digit; a
// word with req_type raw sends one frame of raw_command and raw_payload.
// Requests are taken only while idle; one that arrives while frames are in
// progress is dropped and its response word has rsp_rejected set.
// Every request word yields exactly one response word with the pin levels
// driven during that tick, busy and rejected flags.
// The response word is registered on the edge that takes the request.
// Throughput is one word per cycle, set by the single response register,
// which accepts a new word on the same edge that the receiver takes the
// old one. When the receiver stalls, req_ready falls once the response
// register is full and the engine holds its state.
// A frame lasts 56 phases of phase_ticks words each.
// Synchronous reset puts both pins at 1 (bus idle), clears the engine and
// loads the register defaults; configuration is written through csr_we,
// csr_index and csr_wdata, one register per cycle.
module seven_segment_two_wire_writer import sstw_pkg::*; #(
   parameter int COUNTER_WIDTH = SSTW_COUNTER_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [3:0]             req_digit_a,
   input  logic [3:0]             req_digit_b,
   input  logic [3:0]             req_digit_c,
   input  logic [3:0]             req_digit_d,
   input  logic                   req_dot_on,
   input  logic [7:0]             req_raw_command,
   input  logic [7:0]             req_raw_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_clock_pin,
   output logic                   rsp_data_pin,
   output logic                   rsp_busy_res,
   output logic                   rsp_rejected,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   request_type request;
   result_type  result;
   logic        step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   assign request = '{req_type:    req_type,
                      digit_a:     req_digit_a,
                      digit_b:     req_digit_b,
                      digit_c:     req_digit_c,
                      digit_d:     req_digit_d,
                      dot_on:      req_dot_on,
                      raw_command: req_raw_command,
                      raw_payload: req_raw_payload};

   sstw_engine #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .request (request),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks      <= PHASE_TICKS_W'(100);
         cfg_ff.digit_address[0] <= 8'd104;
         cfg_ff.digit_address[1] <= 8'd106;
         cfg_ff.digit_address[2] <= 8'd108;
         cfg_ff.digit_address[3] <= 8'd110;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_TICKS: cfg_ff.phase_ticks      <= csr_wdata;
            CSR_DIGIT0_ADDR: cfg_ff.digit_address[0] <= csr_wdata[7:0];
            CSR_DIGIT1_ADDR: cfg_ff.digit_address[1] <= csr_wdata[7:0];
            CSR_DIGIT2_ADDR: cfg_ff.digit_address[2] <= csr_wdata[7:0];
            CSR_DIGIT3_ADDR: cfg_ff.digit_address[3] <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_clock_pin = rsp_ff.clock_pin;
   assign rsp_data_pin  = rsp_ff.data_pin;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_rejected  = rsp_ff.rejected;

endmodule
